[rtl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted
`define MHD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define MHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mhd_pkg.sv]
// Types and constants for the message header deframer.
// No dependencies; used by the channel interfaces and the top level.
package mhd_pkg;

	// Field widths
	localparam int WORD_W    = 32;
	localparam int ID_W      = 4;
	localparam int KIND_W    = 4;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 5;
	localparam int CFG_IDX_W = 3;

	// Checksum words collected after a checksum header
	localparam int CHECK_WORDS = 4;
	localparam int CHK_IDX_W   = 2;
	localparam logic [CHK_IDX_W-1:0] CHK_LAST = CHK_IDX_W'(CHECK_WORDS - 1);

	// Header version that is accepted
	localparam logic [7:0] HDR_VERSION = 8'd1;

	// Reset value of the id count registers
	localparam logic [COUNT_W-1:0] COUNT_RST = 5'd16;

	// Message type codes (header bits 23:20)
	localparam logic [3:0] MT_RESET    = 4'd0;
	localparam logic [3:0] MT_CSUM_REQ = 4'd1;
	localparam logic [3:0] MT_CSUM     = 4'd2;
	localparam logic [3:0] MT_DEBUG    = 4'd7;
	localparam logic [3:0] MT_DATA     = 4'd9;
	localparam logic [3:0] MT_POLL     = 4'd10;
	localparam logic [3:0] MT_GPIO     = 4'd14;
	localparam logic [3:0] MT_ACK      = 4'd15;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXP0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXP1      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXP2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP3      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_PORTS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IN_PORTS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GPIO_CNT  = 3'd6;

	// Event kinds on the output channel
	typedef enum logic [KIND_W-1:0] {
		EV_RESET      = 4'd0,
		EV_CHECK_OK   = 4'd1,
		EV_CHECK_BAD  = 4'd2,
		EV_DEBUG_WORD = 4'd3,
		EV_DATA_WORD  = 4'd4,
		EV_POLL       = 4'd5,
		EV_GPIO       = 4'd6,
		EV_ACK        = 4'd7,
		EV_BAD_VER    = 4'd8,
		EV_BAD_TYPE   = 4'd9,
		EV_BAD_ID     = 4'd10
	} ev_kind_t;

	// Deframer phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_CHECK  = 2'd1,
		PH_DEBUG  = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

endpackage

[rtl/mhd_if.sv]
// Valid/ready channel interfaces of the message header deframer.
// Depends on mhd_pkg for field widths.

// Incoming link words
interface mhd_in_if import mhd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] link_word;
	modport source (output valid, output link_word, input ready);
	modport sink   (input valid, input link_word, output ready);
endinterface

// Outgoing events
interface mhd_out_if import mhd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [ID_W-1:0]   target_id;
	logic [WORD_W-1:0] event_value;
	logic              last_word;
	modport source (output valid, output event_kind, output target_id,
		output event_value, output last_word, input ready);
	modport sink   (input valid, input event_kind, input target_id,
		input event_value, input last_word, output ready);
endinterface

// Configuration register writes
interface mhd_cfg_if import mhd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/message_header_deframer_top.sv]
// Message header deframer: splits a stream of link words into events.
// Depends on mhd_pkg, the channel interfaces in mhd_if.sv and assert_macros.svh.
//
// Usage:
//   link   - valid/ready stream of 32-bit link words (headers and payload).
//   events - valid/ready stream of events: kind, target id, value, last flag.
//   cfg    - register writes (index, data); always ready. Write only while
//            the block is idle: no word held and no event pending.
// A word is taken into an input register, decoded against the phase state
// while it is held there, and its event (if any) lands in the output register.
// Throughput: one word per cycle while the event sink keeps ready high;
// the phase machine and all compares are combinational.
// Stall: while an event waits on events.ready it stays in the output register;
// one more word can still be taken into the input register, then link.ready drops.
// Reset (arst_n low): phase returns to header, check words clear to zero,
// the three id counts return to 16, and both registers empty.
`include "assert_macros.svh"

module message_header_deframer_top import mhd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mhd_in_if.sink    link,
	mhd_out_if.source events,
	mhd_cfg_if.sink   cfg
);

	// Configuration registers
	logic [WORD_W-1:0]  exp_q [CHECK_WORDS];
	logic [COUNT_W-1:0] out_ports_q;
	logic [COUNT_W-1:0] in_ports_q;
	logic [COUNT_W-1:0] gpio_cnt_q;

	// Input stage
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              adv;

	// Phase state
	phase_t               state_q, state_d;
	logic [SIZE_W-1:0]    words_left_q, words_left_d;
	logic [ID_W-1:0]      held_id_q, held_id_d;
	logic [CHK_IDX_W-1:0] chk_idx_q, chk_idx_d;
	logic                 all_match_q, all_match_d;

	// Event from the current word
	logic              emit;
	ev_kind_t          e_kind;
	logic [ID_W-1:0]   e_id;
	logic [WORD_W-1:0] e_value;
	logic              e_last;

	// Output register
	logic              out_valid_q;
	ev_kind_t          kind_q;
	logic [ID_W-1:0]   id_q;
	logic [WORD_W-1:0] value_q;
	logic              last_q;

	// Header fields of the held word
	logic [7:0]        hdr_ver;
	logic [3:0]        hdr_type;
	logic [ID_W-1:0]   hdr_id;
	logic [SIZE_W-1:0] hdr_size;

	assign hdr_ver  = word_s1[31:24];
	assign hdr_type = word_s1[23:20];
	assign hdr_id   = word_s1[19:16];
	assign hdr_size = word_s1[15:0];

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHECK_WORDS; i++) begin
				exp_q[i] <= '0;
			end
			out_ports_q <= COUNT_RST;
			in_ports_q  <= COUNT_RST;
			gpio_cnt_q  <= COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_EXP0, REG_EXP1, REG_EXP2, REG_EXP3: begin
					if (32'(cfg.index) < CHECK_WORDS) begin
						exp_q[cfg.index[CHK_IDX_W-1:0]] <= cfg.data;
					end
				end
				REG_OUT_PORTS: out_ports_q <= cfg.data[COUNT_W-1:0];
				REG_IN_PORTS:  in_ports_q  <= cfg.data[COUNT_W-1:0];
				REG_GPIO_CNT:  gpio_cnt_q  <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: the held word moves on when the output register has room
	assign adv        = valid_s1 && (!out_valid_q || events.ready);
	assign link.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link.ready) begin
			valid_s1 <= link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link.valid && link.ready) begin
			word_s1 <= link.link_word;
		end
	end

	// Phase state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= PH_HEADER;
			words_left_q <= '0;
			held_id_q    <= '0;
			chk_idx_q    <= '0;
			all_match_q  <= 1'b1;
		end else begin
			state_q      <= state_d;
			words_left_q <= words_left_d;
			held_id_q    <= held_id_d;
			chk_idx_q    <= chk_idx_d;
			all_match_q  <= all_match_d;
		end
	end

	// Next state and event for the held word
	always_comb begin
		logic do_decode;
		logic match_now;
		state_d      = state_q;
		words_left_d = words_left_q;
		held_id_d    = held_id_q;
		chk_idx_d    = chk_idx_q;
		all_match_d  = all_match_q;
		emit         = 1'b0;
		e_kind       = EV_RESET;
		e_id         = '0;
		e_value      = '0;
		e_last       = 1'b0;
		do_decode    = 1'b0;
		match_now    = all_match_q && (word_s1 == exp_q[chk_idx_q]);

		if (adv) begin
			case (state_q)
				PH_CHECK: begin
					all_match_d = match_now;
					if (chk_idx_q == CHK_LAST) begin
						state_d   = PH_HEADER;
						chk_idx_d = '0;
						emit      = 1'b1;
						e_kind    = match_now ? EV_CHECK_OK : EV_CHECK_BAD;
					end else begin
						chk_idx_d = chk_idx_q + 1'b1;
					end
				end
				PH_DEBUG, PH_DATA: begin
					if (words_left_q != '0) begin
						words_left_d = words_left_q - 1'b1;
						emit         = 1'b1;
						e_kind       = (state_q == PH_DEBUG) ? EV_DEBUG_WORD : EV_DATA_WORD;
						e_id         = held_id_q;
						e_value      = word_s1;
						e_last       = (words_left_q == SIZE_W'(1));
						if (e_last) begin
							state_d = PH_HEADER;
						end
					end else begin
						do_decode = 1'b1;
					end
				end
				default: do_decode = 1'b1;
			endcase
		end

		// Header decode
		if (do_decode) begin
			state_d = PH_HEADER;
			if (hdr_ver != HDR_VERSION) begin
				emit    = 1'b1;
				e_kind  = EV_BAD_VER;
				e_id    = hdr_id;
				e_value = {24'b0, hdr_ver};
			end else begin
				case (hdr_type)
					MT_RESET: begin
						emit   = 1'b1;
						e_kind = EV_RESET;
					end
					MT_CSUM_REQ: ;
					MT_CSUM: begin
						state_d     = PH_CHECK;
						chk_idx_d   = '0;
						all_match_d = 1'b1;
					end
					MT_DEBUG: begin
						if (hdr_size != '0) begin
							state_d      = PH_DEBUG;
							words_left_d = hdr_size;
							held_id_d    = hdr_id;
						end
					end
					MT_DATA: begin
						if (hdr_size != '0) begin
							if ({1'b0, hdr_id} >= out_ports_q) begin
								emit    = 1'b1;
								e_kind  = EV_BAD_ID;
								e_id    = hdr_id;
								e_value = {28'b0, hdr_type};
							end else begin
								state_d      = PH_DATA;
								words_left_d = hdr_size;
								held_id_d    = hdr_id;
							end
						end
					end
					MT_POLL, MT_ACK: begin
						emit = 1'b1;
						e_id = hdr_id;
						if ({1'b0, hdr_id} >= in_ports_q) begin
							e_kind  = EV_BAD_ID;
							e_value = {28'b0, hdr_type};
						end else if (hdr_type == MT_POLL) begin
							e_kind = EV_POLL;
						end else begin
							e_kind  = EV_ACK;
							e_value = {16'b0, hdr_size};
						end
					end
					MT_GPIO: begin
						emit = 1'b1;
						e_id = hdr_id;
						if ({1'b0, hdr_id} >= gpio_cnt_q) begin
							e_kind  = EV_BAD_ID;
							e_value = {28'b0, hdr_type};
						end else begin
							e_kind  = EV_GPIO;
							e_value = {16'b0, hdr_size};
						end
					end
					default: begin
						emit    = 1'b1;
						e_kind  = EV_BAD_TYPE;
						e_id    = hdr_id;
						e_value = {28'b0, hdr_type};
					end
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q  <= e_kind;
			id_q    <= e_id;
			value_q <= e_value;
			last_q  <= e_last;
		end
	end

	assign events.valid       = out_valid_q;
	assign events.event_kind  = kind_q;
	assign events.target_id   = id_q;
	assign events.event_value = value_q;
	assign events.last_word   = last_q;

	// Checks
	`MHD_ASSERT(a_payload_has_words, clk, arst_n, (state_q == PH_DEBUG || state_q == PH_DATA) |-> (words_left_q != '0), "payload phase with no words left")
	`MHD_ASSERT(a_chk_idx_idle, clk, arst_n, (state_q != PH_CHECK) |-> (chk_idx_q == '0), "check index not cleared outside checksum phase")
	`MHD_ASSERT(a_last_on_payload, clk, arst_n, (out_valid_q && last_q) |-> (kind_q == EV_DEBUG_WORD || kind_q == EV_DATA_WORD), "last flag on a non-payload event")
	`MHD_ASSERT(a_held_word_waits, clk, arst_n, (valid_s1 && !adv) |=> (valid_s1 && $stable(word_s1)), "held word lost while output stalled")

endmodule
